// File: hdl/assert_macros.svh
// Assertion shorthands for the Life grid engine RTL.
// Standalone header; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Expression must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

// File: hdl/tlge_pkg.sv
// Shared types, codes and helper functions for the toroidal Life grid engine.
// No dependencies; imported by the top level.
package tlge_pkg;

    localparam int COORD_W          = 7;
    localparam int COUNT_W          = 4;
    localparam int ACTION_W         = 2;
    localparam int DEF_GRID_COLUMNS = 128;
    localparam int DEF_GRID_ROWS    = 128;
    localparam int BIRTH_COUNT      = 3;
    localparam int STAY_COUNT       = 2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_SET     = 2'd0,
        ACT_CLEAR   = 2'd1,
        ACT_ADVANCE = 2'd2,
        ACT_READ    = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        DIR_ZERO  = 2'd0,
        DIR_MINUS = 2'd1,
        DIR_PLUS  = 2'd2
    } t_dir;

    typedef struct packed {
        t_dir dx;
        t_dir dy;
    } t_nbr_dir;

    // Walk order of the eight neighbors, row above first.
    function automatic t_nbr_dir nbr_dir(input logic [2:0] k);
        t_nbr_dir d;
        case (k)
            3'd0:    d = '{dx: DIR_MINUS, dy: DIR_MINUS};
            3'd1:    d = '{dx: DIR_ZERO,  dy: DIR_MINUS};
            3'd2:    d = '{dx: DIR_PLUS,  dy: DIR_MINUS};
            3'd3:    d = '{dx: DIR_MINUS, dy: DIR_ZERO};
            3'd4:    d = '{dx: DIR_PLUS,  dy: DIR_ZERO};
            3'd5:    d = '{dx: DIR_MINUS, dy: DIR_PLUS};
            3'd6:    d = '{dx: DIR_ZERO,  dy: DIR_PLUS};
            default: d = '{dx: DIR_PLUS,  dy: DIR_PLUS};
        endcase
        return d;
    endfunction

    // B3/S23 rule.
    function automatic logic life_rule(input logic alive, input logic [COUNT_W-1:0] cnt);
        logic birth;
        logic stay;
        birth = (cnt == COUNT_W'(BIRTH_COUNT));
        stay  = (cnt == COUNT_W'(STAY_COUNT)) || birth;
        return alive ? stay : birth;
    endfunction

endpackage

// File: hdl/tlge_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module tlge_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/toroidal_life_grid_engine.sv
// Toroidal Life grid engine top level: sequencer, count update unit, three grid RAMs.
// Depends on tlge_pkg, tlge_ram and assert_macros.svh.
//
// Holds a GRID_COLUMNS x GRID_ROWS wrap-around grid (N cells) of live/dead cells
// and a per-cell live-neighbor count, handles one request at a time and returns
// one result per request. After reset a clearing pass over all N cells runs with
// s_axis_tready low. A set or clear that toggles a cell has one shared
// read-modify-write unit walk the eight neighbor counts one per cycle. An
// advance makes one pass over every cell to apply B3/S23 and zero the counts,
// then a second pass that copies the new states into the live cells and has
// the same unit add one to the eight neighbor counts of each live cell. The
// count RAM has a single write port, so these updates go one at a time.
// s_axis_tready rises in the same cycle as the result is registered. A finished
// result waits in an output register, and the next request is taken while it does.
`include "assert_macros.svh"

module toroidal_life_grid_engine
    import tlge_pkg::*;
#(
    parameter int GRID_COLUMNS = DEF_GRID_COLUMNS,
    parameter int GRID_ROWS    = DEF_GRID_ROWS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [6:0] cell_column, [13:7] cell_row, [15:14] zero
    input  logic [1:0]  s_axis_tuser,   // [1:0] action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // [0] cell_alive, [4:1] neighbour_count, [7:5] zero
);

    localparam int CELLS  = GRID_COLUMNS * GRID_ROWS;
    localparam int IDX_W  = $clog2(CELLS);
    localparam int COL_W  = $clog2(GRID_COLUMNS);
    localparam int ROW_W  = $clog2(GRID_ROWS);

    localparam logic [IDX_W-1:0] LAST_I  = IDX_W'(CELLS - 1);
    localparam logic [IDX_W-1:0] COLS_I  = IDX_W'(GRID_COLUMNS);
    localparam logic [IDX_W-1:0] COLM1_I = IDX_W'(GRID_COLUMNS - 1);
    localparam logic [IDX_W-1:0] WRAP_I  = IDX_W'(CELLS - GRID_COLUMNS);
    localparam logic [IDX_W-1:0] ONE_I   = IDX_W'(1);
    localparam logic [COL_W-1:0] LAST_COL = COL_W'(GRID_COLUMNS - 1);
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(GRID_ROWS - 1);

    typedef enum logic [3:0] {
        ST_CLR,
        ST_IDLE,
        ST_CALC,
        ST_EDIT_RD,
        ST_EDIT_CHK,
        ST_NBR,
        ST_NBR_END,
        ST_ADV_A,
        ST_ADV_A_END,
        ST_ADV_C_RD,
        ST_ADV_C_WR,
        ST_RD,
        ST_RD_WAIT
    } t_state;

    t_state               r_state,     n_state;
    t_action              r_act,       n_act;
    logic                 r_inside,    n_inside;
    logic [COL_W-1:0]     r_col,       n_col;
    logic [ROW_W-1:0]     r_row,       n_row;
    logic [IDX_W-1:0]     r_idx,       n_idx;
    logic [IDX_W-1:0]     r_req_idx,   n_req_idx;
    logic [IDX_W-1:0]     r_sweep,     n_sweep;
    logic [2:0]           r_k,         n_k;
    logic                 r_add,       n_add;
    logic                 r_ret_adv,   n_ret_adv;
    logic                 r_pv,        n_pv;
    logic [IDX_W-1:0]     r_pa,        n_pa;
    logic                 r_nv,        n_nv;
    logic [IDX_W-1:0]     r_nwa,       n_nwa;
    logic                 r_m_valid,   n_m_valid;
    logic                 r_res_alive, n_res_alive;
    logic [COUNT_W-1:0]   r_res_cnt,   n_res_cnt;

    // RAM ports
    logic                 live_we,  cnt_we,  nxt_we;
    logic [IDX_W-1:0]     live_wa,  cnt_wa,  nxt_wa;
    logic                 live_wd,  nxt_wd;
    logic [COUNT_W-1:0]   cnt_wd;
    logic [IDX_W-1:0]     live_ra,  cnt_ra;
    logic                 live_rd,  nxt_rd;
    logic [COUNT_W-1:0]   cnt_rd;

    logic                 s_accept;
    logic                 out_free;
    logic                 edit_change;
    logic                 cell_last;
    logic [COL_W-1:0]     step_col;
    logic [ROW_W-1:0]     step_row;
    t_nbr_dir             dir;
    logic [IDX_W-1:0]     col_adj;
    logic [IDX_W-1:0]     nbr_addr;
    logic [COORD_W-1:0]   in_col;
    logic [COORD_W-1:0]   in_row;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_m_valid || m_axis_tready;
    assign in_col        = s_axis_tdata[COORD_W-1:0];
    assign in_row        = s_axis_tdata[2*COORD_W-1:COORD_W];

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {3'b000, r_res_cnt, r_res_alive};

    // Neighbor address with wrap at both edges, built off the center index.
    always_comb begin
        dir = nbr_dir(r_k);
        case (dir.dx)
            DIR_MINUS: col_adj = (r_col == '0) ? r_idx + COLM1_I : r_idx - ONE_I;
            DIR_PLUS:  col_adj = (r_col == LAST_COL) ? r_idx - COLM1_I : r_idx + ONE_I;
            default:   col_adj = r_idx;
        endcase
        case (dir.dy)
            DIR_MINUS: nbr_addr = (r_row == '0) ? col_adj + WRAP_I : col_adj - COLS_I;
            DIR_PLUS:  nbr_addr = (r_row == LAST_ROW) ? col_adj - WRAP_I : col_adj + COLS_I;
            default:   nbr_addr = col_adj;
        endcase
    end

    assign edit_change = ((r_act == ACT_SET) && !live_rd) || ((r_act == ACT_CLEAR) && live_rd);
    assign cell_last   = (r_idx == LAST_I);
    assign step_col    = (r_col == LAST_COL) ? '0 : r_col + COL_W'(1);
    assign step_row    = (r_col == LAST_COL) ? r_row + ROW_W'(1) : r_row;

    // RAM port steering
    always_comb begin
        live_we = (r_state == ST_CLR) || (r_state == ST_ADV_C_WR)
                  || ((r_state == ST_EDIT_CHK) && edit_change);
        live_wa = (r_state == ST_CLR) ? r_sweep : r_idx;
        if (r_state == ST_CLR) begin
            live_wd = 1'b0;
        end else if (r_state == ST_EDIT_CHK) begin
            live_wd = (r_act == ACT_SET);
        end else begin
            live_wd = nxt_rd;
        end
        if (r_state == ST_ADV_A) begin
            live_ra = r_sweep;
        end else if (r_state == ST_EDIT_RD) begin
            live_ra = r_idx;
        end else begin
            live_ra = r_req_idx;
        end

        cnt_we = (r_state == ST_CLR) || r_pv || r_nv;
        if (r_state == ST_CLR) begin
            cnt_wa = r_sweep;
        end else if (r_pv) begin
            cnt_wa = r_pa;
        end else begin
            cnt_wa = r_nwa;
        end
        if ((r_state == ST_CLR) || r_pv) begin
            cnt_wd = '0;
        end else if (r_add) begin
            cnt_wd = cnt_rd + COUNT_W'(1);
        end else begin
            cnt_wd = cnt_rd - COUNT_W'(1);
        end
        if (r_state == ST_ADV_A) begin
            cnt_ra = r_sweep;
        end else if (r_state == ST_NBR) begin
            cnt_ra = nbr_addr;
        end else begin
            cnt_ra = r_req_idx;
        end

        nxt_we = (r_state == ST_CLR) || r_pv;
        nxt_wa = (r_state == ST_CLR) ? r_sweep : r_pa;
        nxt_wd = (r_state == ST_CLR) ? 1'b0 : life_rule(live_rd, cnt_rd);
    end

    // Sequencer
    always_comb begin
        n_state     = r_state;
        n_act       = r_act;
        n_inside    = r_inside;
        n_col       = r_col;
        n_row       = r_row;
        n_idx       = r_idx;
        n_req_idx   = r_req_idx;
        n_sweep     = r_sweep;
        n_k         = r_k;
        n_add       = r_add;
        n_ret_adv   = r_ret_adv;
        n_pv        = 1'b0;
        n_pa        = r_pa;
        n_nv        = 1'b0;
        n_nwa       = r_nwa;
        n_m_valid   = r_m_valid && !m_axis_tready;
        n_res_alive = r_res_alive;
        n_res_cnt   = r_res_cnt;

        case (r_state)
            ST_CLR: begin
                n_sweep = r_sweep + ONE_I;
                if (r_sweep == LAST_I) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_accept) begin
                    n_act    = t_action'(s_axis_tuser);
                    n_inside = (int'(in_col) < GRID_COLUMNS) && (int'(in_row) < GRID_ROWS);
                    n_col    = COL_W'(in_col);
                    n_row    = ROW_W'(in_row);
                    n_state  = ST_CALC;
                end
            end
            ST_CALC: begin
                n_req_idx = IDX_W'(r_row) * COLS_I + IDX_W'(r_col);
                n_idx     = n_req_idx;
                if (r_act == ACT_ADVANCE) begin
                    n_idx   = '0;
                    n_col   = '0;
                    n_row   = '0;
                    n_sweep = '0;
                    n_state = ST_ADV_A;
                end else if (r_inside && ((r_act == ACT_SET) || (r_act == ACT_CLEAR))) begin
                    n_state = ST_EDIT_RD;
                end else begin
                    n_state = ST_RD;
                end
            end
            ST_EDIT_RD: begin
                n_state = ST_EDIT_CHK;
            end
            ST_EDIT_CHK: begin
                if (edit_change) begin
                    n_add     = (r_act == ACT_SET);
                    n_ret_adv = 1'b0;
                    n_k       = '0;
                    n_state   = ST_NBR;
                end else begin
                    n_state = ST_RD;
                end
            end
            ST_NBR: begin
                // issue read of neighbor k; write back lands next cycle
                n_nv  = 1'b1;
                n_nwa = nbr_addr;
                n_k   = r_k + 3'd1;
                if (r_k == 3'd7) begin
                    n_state = ST_NBR_END;
                end
            end
            ST_NBR_END: begin
                if (!r_ret_adv || cell_last) begin
                    n_state = ST_RD;
                end else begin
                    n_idx   = r_idx + ONE_I;
                    n_col   = step_col;
                    n_row   = step_row;
                    n_state = ST_ADV_C_RD;
                end
            end
            ST_ADV_A: begin
                // rule pass; counts zeroed behind the read pointer
                n_pv    = 1'b1;
                n_pa    = r_sweep;
                n_sweep = r_sweep + ONE_I;
                if (r_sweep == LAST_I) begin
                    n_state = ST_ADV_A_END;
                end
            end
            ST_ADV_A_END: begin
                n_state = ST_ADV_C_RD;
            end
            ST_ADV_C_RD: begin
                n_state = ST_ADV_C_WR;
            end
            ST_ADV_C_WR: begin
                if (nxt_rd) begin
                    n_add     = 1'b1;
                    n_ret_adv = 1'b1;
                    n_k       = '0;
                    n_state   = ST_NBR;
                end else if (cell_last) begin
                    n_state = ST_RD;
                end else begin
                    n_idx   = r_idx + ONE_I;
                    n_col   = step_col;
                    n_row   = step_row;
                    n_state = ST_ADV_C_RD;
                end
            end
            ST_RD: begin
                n_state = ST_RD_WAIT;
            end
            ST_RD_WAIT: begin
                // hold the read address until the output register frees up
                if (out_free) begin
                    n_m_valid   = 1'b1;
                    n_res_alive = r_inside && live_rd;
                    n_res_cnt   = r_inside ? cnt_rd : '0;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLR;
            r_sweep   <= '0;
            r_k       <= '0;
            r_pv      <= 1'b0;
            r_nv      <= 1'b0;
            r_ret_adv <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_sweep   <= n_sweep;
            r_k       <= n_k;
            r_pv      <= n_pv;
            r_nv      <= n_nv;
            r_ret_adv <= n_ret_adv;
            r_m_valid <= n_m_valid;
        end
        r_act       <= n_act;
        r_inside    <= n_inside;
        r_col       <= n_col;
        r_row       <= n_row;
        r_idx       <= n_idx;
        r_req_idx   <= n_req_idx;
        r_add       <= n_add;
        r_pa        <= n_pa;
        r_nwa       <= n_nwa;
        r_res_alive <= n_res_alive;
        r_res_cnt   <= n_res_cnt;
    end

    tlge_ram #(.WIDTH(1), .DEPTH(CELLS)) u_live_ram (
        .i_clk   (i_clk),
        .i_we    (live_we),
        .i_waddr (live_wa),
        .i_wdata (live_wd),
        .i_raddr (live_ra),
        .o_rdata (live_rd)
    );

    tlge_ram #(.WIDTH(COUNT_W), .DEPTH(CELLS)) u_cnt_ram (
        .i_clk   (i_clk),
        .i_we    (cnt_we),
        .i_waddr (cnt_wa),
        .i_wdata (cnt_wd),
        .i_raddr (cnt_ra),
        .o_rdata (cnt_rd)
    );

    tlge_ram #(.WIDTH(1), .DEPTH(CELLS)) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (nxt_we),
        .i_waddr (nxt_wa),
        .i_wdata (nxt_wd),
        .i_raddr (r_idx),
        .o_rdata (nxt_rd)
    );

    `ASSERT_NEVER(a_cnt_one_writer, i_clk, i_rst_n, r_pv && r_nv, "two count writers at once")
    `ASSERT_ALWAYS(a_nbr_no_hazard, i_clk, i_rst_n, ((r_state == ST_NBR) && r_nv) |-> (nbr_addr != r_nwa), "neighbor read hits pending write")
    `ASSERT_ALWAYS(a_busy_after_accept, i_clk, i_rst_n, s_accept |=> !s_axis_tready, "ready after accept")
    `ASSERT_ALWAYS(a_result_source, i_clk, i_rst_n, $rose(m_axis_tvalid) |-> ($past(r_state) == ST_RD_WAIT), "result without read")

endmodule
